### hw/rtl/sfd_pkg.sv
// Shared constants and widths of the SBUS frame decoder.
package sfd_pkg;

   localparam int DATA_BYTES   = 22;
   localparam int NUM_CHANNELS = 16;
   localparam int CHANNEL_BITS = 11;
   localparam int BYTE_W       = 8;
   localparam int FLAGS_W      = 8;
   localparam int CHAN_W       = 4;
   localparam int COUNT_W      = 5;
   localparam int FRAME_BITS   = DATA_BYTES * BYTE_W;

   localparam logic [BYTE_W-1:0]  START_BYTE   = 8'h0F;
   localparam logic [BYTE_W-1:0]  END_BYTE     = 8'h00;
   localparam logic [CHAN_W-1:0]  LAST_CHANNEL = CHAN_W'(NUM_CHANNELS - 1);
   localparam logic [COUNT_W-1:0] FIRST_DATA   = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] FLAG_POS     = COUNT_W'(DATA_BYTES + 1);

   typedef logic [FRAME_BITS-1:0] frame_type;

endpackage

### hw/rtl/sfd_if.sv
// Valid/ready channel interfaces for received bytes and decoded channel results.
interface sfd_req_if;
   import sfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   import sfd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CHAN_W-1:0]       channel_index;
   logic [CHANNEL_BITS-1:0] channel_value;
   logic [FLAGS_W-1:0]      frame_flags;
   logic                    last_channel;

   modport source (output valid, output channel_index, output channel_value,
                   output frame_flags, output last_channel, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input frame_flags, input last_channel, output ready);
endinterface

### hw/rtl/sbus_frame_decoder_top.sv
// SBUS frame decoder: byte-stream framing, frame capture and channel burst output.
// One received byte is taken per cycle. After a start byte the 22 data bytes are
// shifted into a frame register and the flag byte is held; a correct end byte
// copies the frame into a burst register, which then presents 16 channel results,
// one per cycle while the sink takes them, with the last one marked. Bytes keep
// flowing in during a burst; only an end byte that arrives while a burst is still
// being delivered is held off until the burst register frees, so the sustained
// rate is one byte per cycle and the burst register sets the only stall.
module sbus_frame_decoder_top (
   input  logic      clock,
   input  logic      reset,
   sfd_req_if.sink   req_chan,
   sfd_rsp_if.source rsp_chan
);
   import sfd_pkg::*;

   logic                in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   frame_type           frame_ff, frame_in;
   logic [FLAGS_W-1:0]  flag_hold_ff, flag_hold_in;

   logic                busy_ff, busy_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   frame_type           snap_ff, snap_in;
   logic [FLAGS_W-1:0]  rsp_flags_ff, rsp_flags_in;

   logic                req_fire;
   logic                rsp_fire;
   logic                at_end;
   logic                load;

   assign at_end   = in_frame_ff && (byte_count_ff > FLAG_POS);
   assign req_chan.ready = !(at_end && busy_ff);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign load     = req_fire && at_end && (req_chan.rx_byte == END_BYTE);

   always_comb begin
      in_frame_in   = in_frame_ff;
      byte_count_in = byte_count_ff;
      frame_in      = frame_ff;
      flag_hold_in  = flag_hold_ff;
      if (req_fire) begin
         if (!in_frame_ff) begin
            if (req_chan.rx_byte == START_BYTE) begin
               in_frame_in   = 1'b1;
               byte_count_in = FIRST_DATA;
            end
         end else if (at_end) begin
            in_frame_in   = 1'b0;
            byte_count_in = '0;
         end else if (byte_count_ff == FLAG_POS) begin
            flag_hold_in  = req_chan.rx_byte;
            byte_count_in = byte_count_ff + COUNT_W'(1);
         end else begin
            frame_in      = {req_chan.rx_byte, frame_ff[FRAME_BITS-1:BYTE_W]};
            byte_count_in = byte_count_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      chan_in      = chan_ff;
      snap_in      = snap_ff;
      rsp_flags_in = rsp_flags_ff;
      if (rsp_fire) begin
         chan_in = chan_ff + CHAN_W'(1);
         snap_in = snap_ff >> CHANNEL_BITS;
         if (chan_ff == LAST_CHANNEL) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in      = 1'b1;
         chan_in      = '0;
         snap_in      = frame_ff;
         rsp_flags_in = flag_hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_count_ff <= '0;
         flag_hold_ff  <= '0;
         busy_ff       <= 1'b0;
         chan_ff       <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         byte_count_ff <= byte_count_in;
         flag_hold_ff  <= flag_hold_in;
         busy_ff       <= busy_in;
         chan_ff       <= chan_in;
      end
      frame_ff     <= frame_in;
      snap_ff      <= snap_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_chan.valid         = busy_ff;
   assign rsp_chan.channel_index = chan_ff;
   assign rsp_chan.channel_value = snap_ff[CHANNEL_BITS-1:0];
   assign rsp_chan.frame_flags   = rsp_flags_ff;
   assign rsp_chan.last_channel  = (chan_ff == LAST_CHANNEL);

`ifndef SYNTH
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy_ff)
      else $error("frame loaded over a burst in progress");

   a_burst_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && chan_ff == '0))
      else $error("burst did not start at channel zero");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_chan.last_channel && !load) |=> !busy_ff)
      else $error("burst continued past the last channel");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (byte_count_ff != '0 && byte_count_ff <= FLAG_POS + COUNT_W'(1)))
      else $error("byte count out of frame range");

   a_hunt_count_clear: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> byte_count_ff == '0)
      else $error("byte count not cleared while hunting");
`endif

endmodule

### tb/sbus_frame_decoder_top_tb.sv
// Self-checking testbench for the SBUS frame decoder: byte stream in, channel results checked.
`timescale 1ns / 100ps

module sbus_frame_decoder_top_tb;
   import sfd_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0]       channel_index;
      logic [CHANNEL_BITS-1:0] channel_value;
      logic [FLAGS_W-1:0]      frame_flags;
      logic                    last_channel;
   } channel_result_type;

   typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_mode_type;

   logic clock;
   logic reset;

   sfd_req_if req_bus ();
   sfd_rsp_if rsp_bus ();

   sbus_frame_decoder_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [BYTE_W-1:0]  byte_queue [$];
   channel_result_type channel_queue [$];

   int send_idle_pct;
   int recv_idle_pct;
   bit req_taken;
   int queued_total;
   int accepted_total;
   int mismatches;
   int results_checked;
   int good_frames;
   int bad_frames;
   int frame_num;

   // decoder state mirror
   logic                 in_frame_m;
   logic [COUNT_W-1:0]   frame_pos;
   logic [BYTE_W-1:0]    frame_bytes [DATA_BYTES];
   logic [FLAGS_W-1:0]   flags_held;

   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      frame_type          bits;
      channel_result_type res;
      if (!in_frame_m) begin
         if (b == START_BYTE) begin
            in_frame_m = 1'b1;
            frame_pos  = FIRST_DATA;
         end
      end else if (frame_pos >= FIRST_DATA && frame_pos <= COUNT_W'(DATA_BYTES)) begin
         frame_bytes[frame_pos - COUNT_W'(1)] = b;
         frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == '0) begin
         frame_bytes[0] = b;
         frame_pos = COUNT_W'(2);
      end else if (frame_pos == FLAG_POS) begin
         flags_held = b;
         frame_pos  = frame_pos + 1'b1;
      end else begin
         in_frame_m = 1'b0;
         frame_pos  = '0;
         if (b == END_BYTE) begin
            good_frames++;
            for (int i = 0; i < DATA_BYTES; i++)
               bits[i*BYTE_W +: BYTE_W] = frame_bytes[i];
            for (int k = 0; k < NUM_CHANNELS; k++) begin
               res.channel_index = CHAN_W'(k);
               res.channel_value = bits[k*CHANNEL_BITS +: CHANNEL_BITS];
               res.frame_flags   = flags_held;
               res.last_channel  = (CHAN_W'(k) == LAST_CHANNEL);
               channel_queue.push_back(res);
            end
         end else begin
            bad_frames++;
         end
      end
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      byte_queue.push_back(b);
      queued_total++;
   endtask

   task automatic push_frame(input fill_mode_type fill, input logic [FLAGS_W-1:0] flags,
                             input logic [BYTE_W-1:0] end_byte);
      logic [BYTE_W-1:0] b;
      push_byte(START_BYTE);
      for (int i = 0; i < DATA_BYTES; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default:   b = ($urandom_range(7) == 0) ? START_BYTE : 8'($urandom);
         endcase
         push_byte(b);
      end
      push_byte(flags);
      push_byte(end_byte);
   endtask

   // mostly well-formed frames, with noise between them and some broken end bytes
   task automatic push_random_frames(input int target);
      int                 count;
      int                 noise_len;
      fill_mode_type      fill;
      logic [FLAGS_W-1:0] flags;
      logic [BYTE_W-1:0]  end_byte;
      logic [BYTE_W-1:0]  b;
      count = 0;
      while (count < target) begin
         if ($urandom_range(2) == 0) begin
            noise_len = $urandom_range(3, 1);
            repeat (noise_len) begin
               b = 8'($urandom);
               if (b == START_BYTE)
                  b = ~START_BYTE;
               push_byte(b);
            end
         end
         case (frame_num % 5)
            1:       fill = FILL_ZERO;
            3:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
         endcase
         case (frame_num % 4)
            0:       flags = 8'h00;
            1:       flags = 8'hFF;
            default: flags = 8'($urandom);
         endcase
         if (frame_num % 3 != 2)
            end_byte = END_BYTE;
         else if (frame_num % 6 == 2)
            end_byte = START_BYTE;
         else
            end_byte = 8'($urandom_range(255, 1));
         push_frame(fill, flags, end_byte);
         frame_num++;
         count += DATA_BYTES + 3;
      end
   endtask

   task automatic drain_all();
      while (accepted_total != queued_total || channel_queue.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // transaction driver for both channels
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid   <= 1'b1;
            req_bus.rx_byte <= byte_queue.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // transaction monitor and checker
   always @(posedge clock) begin
      channel_result_type got;
      channel_result_type want;
      req_taken = !reset && req_bus.valid && req_bus.ready;
      if (reset) begin
         in_frame_m = 1'b0;
         frame_pos  = '0;
         flags_held = '0;
      end else if (req_taken) begin
         decode_byte(req_bus.rx_byte);
         accepted_total++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.channel_index, rsp_bus.channel_value, rsp_bus.frame_flags,
                rsp_bus.last_channel};
         if (channel_queue.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: index %0d value %0d flags %02h last %0b",
                     $realtime, got.channel_index, got.channel_value, got.frame_flags,
                     got.last_channel);
         end else begin
            want = channel_queue.pop_front();
            results_checked++;
            if (got.channel_index !== want.channel_index
                || got.channel_value !== want.channel_value
                || got.frame_flags !== want.frame_flags
                || got.last_channel !== want.last_channel) begin
               mismatches++;
               $display({"%0t: expected index %0d value %0d flags %02h last %0b, ",
                         "got index %0d value %0d flags %02h last %0b"},
                        $realtime, want.channel_index, want.channel_value, want.frame_flags,
                        want.last_channel, got.channel_index, got.channel_value,
                        got.frame_flags, got.last_channel);
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      send_idle_pct   = 38;
      recv_idle_pct   = 71;
      queued_total    = 0;
      accepted_total  = 0;
      mismatches      = 0;
      results_checked = 0;
      good_frames     = 0;
      bad_frames      = 0;
      frame_num       = 0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      push_byte(8'hFF);
      push_byte(END_BYTE);
      push_frame(FILL_ONES, START_BYTE, END_BYTE);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         push_random_frames(50);
         drain_all();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d decoded frames and %0d frames with a bad end byte in %0d bytes.",
               good_frames, bad_frames, accepted_total);
      $display("Checked %0d channel results under sender and receiver stalls.",
               results_checked);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout waiting for channel results");
      $display("Mismatches found");
      $finish;
   end

endmodule
